[sv/recovery_stand_joint_sequencer_macros.svh]
// Assertion macros for the recovery stand joint sequencer.
`ifndef RECOVERY_STAND_JOINT_SEQUENCER_MACROS_SVH
`define RECOVERY_STAND_JOINT_SEQUENCER_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define RSJS_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define RSJS_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[sv/rsjs_pkg.sv]
// Shared constants, types and codes of the recovery stand joint sequencer.
package rsjs_pkg;

    localparam int LEGS      = 4;
    localparam int POS_BITS  = 16;
    localparam int NJ        = 3 * LEGS;
    localparam int IDX_W     = $clog2(NJ);
    localparam int JOINT_W   = 4;
    localparam int TGT_DEPTH = 3 * NJ;
    localparam int TGT_AW    = $clog2(TGT_DEPTH);
    localparam int CFG_W     = 16;
    localparam int CNT_W     = 16;
    localparam int L_W       = 13;
    localparam int FRAC_W    = 12;

    localparam logic signed [15:0] H_STAND_LO = 16'sd819;
    localparam logic signed [15:0] H_STAND_HI = 16'sd1844;
    localparam logic signed [15:0] H_FAIL     = 16'sd410;
    localparam logic [CNT_W-1:0]   CNT_MAX    = '1;

    // Reciprocal of ten, scaled by 2^23, for the seventy percent threshold.
    localparam logic [19:0] RECIP10   = 20'd838861;
    localparam int          RECIP_SH  = 23;

    localparam logic [2:0] CFG_ROLL_RAMP   = 3'd0;
    localparam logic [2:0] CFG_ROLL_SETTLE = 3'd1;
    localparam logic [2:0] CFG_FOLD_RAMP   = 3'd2;
    localparam logic [2:0] CFG_FOLD_SETTLE = 3'd3;
    localparam logic [2:0] CFG_STAND_RAMP  = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_STORE = 2'd1,
        OP_ENTER = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_STAND = 2'd0,
        PH_FOLD  = 2'd1,
        PH_ROLL  = 2'd2,
        PH_NONE  = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ENTER_RD,
        S_ENTER_WR,
        S_FAIL_RD,
        S_FAIL_WR,
        S_RAMP,
        S_JRD,
        S_JMUL,
        S_JOUT
    } seq_state_t;

    typedef enum logic [2:0] {
        R_IDLE,
        R_DIV,
        R_SQ,
        R_CUBE,
        R_DONE
    } ramp_state_t;

endpackage

[sv/rsjs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rsjs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/rsjs_ramp.sv]
// Smoothstep ramp unit: serial divide for l, then two registered multiplies for p.
module rsjs_ramp
    import rsjs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [CNT_W-1:0] count,
    input  logic [CFG_W-1:0] ramp,
    output logic             p_valid,
    output logic [L_W-1:0]   p
);

    ramp_state_t st_reg, st_next;
    logic [CFG_W-1:0]  rem_reg;
    logic [CFG_W-1:0]  ramp_reg;
    logic [FRAC_W-1:0] q_reg;
    logic [L_W-1:0]    l_reg;
    logic [3:0]        it_reg;
    logic [2*L_W-1:0]  sq_reg;
    logic [2*L_W+13:0] cube_reg;
    logic [CFG_W:0]    trial;
    logic              fits;
    logic [13:0]       kfac;

    assign trial = {rem_reg, 1'b0};
    assign fits  = trial >= {1'b0, ramp_reg};
    assign kfac  = 14'd12288 - {l_reg, 1'b0};

    // Next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            R_IDLE:
            begin
                if (go)
                begin
                    st_next = (count >= ramp) ? R_SQ : R_DIV;
                end
            end
            R_DIV:
            begin
                if (it_reg == 4'(FRAC_W - 1))
                begin
                    st_next = R_SQ;
                end
            end
            R_SQ:    st_next = R_CUBE;
            R_CUBE:  st_next = R_DONE;
            R_DONE:  st_next = R_IDLE;
            default: st_next = R_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= R_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // Divide one quotient bit a cycle, then square and scale
    always_ff @(posedge clk)
    begin
        case (st_reg)
            R_IDLE:
            begin
                rem_reg  <= count;
                ramp_reg <= ramp;
                q_reg    <= '0;
                it_reg   <= '0;
                l_reg    <= L_W'(1 << FRAC_W);
            end
            R_DIV:
            begin
                rem_reg <= fits ? CFG_W'(trial - {1'b0, ramp_reg}) : CFG_W'(trial);
                q_reg   <= {q_reg[FRAC_W-2:0], fits};
                it_reg  <= it_reg + 4'd1;
                if (it_reg == 4'(FRAC_W - 1))
                begin
                    l_reg <= {1'b0, q_reg[FRAC_W-2:0], fits};
                end
            end
            R_SQ:
            begin
                sq_reg <= l_reg * l_reg;
            end
            R_CUBE:
            begin
                cube_reg <= sq_reg * kfac;
            end
            default:
            begin
            end
        endcase
    end

    assign p_valid = (st_reg == R_DONE);
    assign p       = cube_reg[24 + L_W - 1:24];

endmodule

[sv/recovery_stand_joint_sequencer.sv]
// Top level of the recovery stand joint sequencer: control, memories and outputs.
//
// Usage: raise start with opcode and fields while busy is low; the beat is taken
// at that edge. Load target (opcode 0) and store feedback (opcode 1) complete at
// the accepting edge and never raise busy. Enter recovery (opcode 2) walks all
// twelve joints to latch start positions while busy, with no result.
// A tick (opcode 3) runs the ramp unit (serial divide, skipped once the
// count has reached the ramp, then the R_SQ and R_CUBE multiplies and the R_DONE
// handoff) and then the S_JRD, S_JMUL and S_JOUT states per joint, giving twelve
// result beats, each shown for one cycle with result_valid high and last set on
// the twelfth. The twelfth beat shows in the same cycle as busy falls.
// A failed stand-up tick walks all twelve joints while busy and emits nothing.
// The receiver cannot stall: result beats are not held.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the
// user must make them only while the block is idle; the block itself does not
// enforce this.
// Reset clears the phase to fold, the count, the done flag and the valid bits
// of feedback and last commands; target and start memories hold garbage until
// written.
`include "recovery_stand_joint_sequencer_macros.svh"

module recovery_stand_joint_sequencer
    import rsjs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 opcode,
    input  logic [JOINT_W-1:0]         joint,
    input  logic [1:0]                 table_select,
    input  logic signed [POS_BITS-1:0] position,
    input  logic                       position_valid,
    input  logic                       upside_down,
    input  logic signed [15:0]         height,
    input  logic                       height_valid,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    output logic                       result_valid,
    output logic [JOINT_W-1:0]         out_joint,
    output logic signed [POS_BITS-1:0] position_command,
    output logic [1:0]                 phase,
    output logic                       complete,
    output logic                       last
);

    localparam int PROD_W = POS_BITS + 1 + L_W + 1;

    seq_state_t st_reg, st_next;

    logic [CFG_W-1:0] roll_ramp_reg, roll_settle_reg, fold_ramp_reg;
    logic [CFG_W-1:0] fold_settle_reg, stand_ramp_reg, stand_lim_reg;
    logic [38:0]      lim_prod;

    phase_t           phase_reg, nphase_reg;
    logic [CNT_W-1:0] count_reg;
    logic             done_reg;
    logic             restart_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [1:0]       op_reg;
    logic             inv_reg, hv_reg;
    logic signed [15:0] h_reg;
    logic [NJ-1:0]    fb_vld_reg, lc_vld_reg;

    logic                       accept;
    logic                       idx_end;
    logic                       failed, fail_hit;
    logic [CNT_W:0]             fold_sum, roll_sum;
    logic                       fold_end, roll_end;
    logic [CFG_W-1:0]           ramp_sel;
    logic                       ramp_go, p_valid;
    logic [L_W-1:0]             p;

    logic                       tgt_we, tgt_re;
    logic [TGT_AW-1:0]          tgt_waddr, tgt_raddr;
    logic [POS_BITS-1:0]        tgt_q;
    logic                       fb_we, fb_re;
    logic [POS_BITS-1:0]        fb_q;
    logic                       sp_we, sp_re;
    logic [POS_BITS-1:0]        sp_wdata, sp_q;
    logic                       lc_we, lc_re;
    logic [POS_BITS-1:0]        lc_q;

    logic signed [POS_BITS-1:0] start_hold_reg, tgt_hold_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [POS_BITS:0]   diff;
    logic signed [PROD_W-1:0]   rnd;
    logic signed [POS_BITS-1:0] cmd;

    assign accept  = start && (st_reg == S_IDLE);
    assign busy    = (st_reg != S_IDLE);
    assign idx_end = (idx_reg == IDX_W'(NJ - 1));

    // Configuration registers and the stand-up failure threshold
    assign lim_prod = (39'(stand_ramp_reg) * 39'd7) * 39'(RECIP10);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_ramp_reg   <= 16'd300;
            roll_settle_reg <= 16'd300;
            fold_ramp_reg   <= 16'd800;
            fold_settle_reg <= 16'd1400;
            stand_ramp_reg  <= 16'd500;
            stand_lim_reg   <= 16'd350;
        end
        else
        begin
            stand_lim_reg <= CFG_W'(lim_prod >> RECIP_SH);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROLL_RAMP:   roll_ramp_reg   <= cfg_data;
                    CFG_ROLL_SETTLE: roll_settle_reg <= cfg_data;
                    CFG_FOLD_RAMP:   fold_ramp_reg   <= cfg_data;
                    CFG_FOLD_SETTLE: fold_settle_reg <= cfg_data;
                    CFG_STAND_RAMP:  stand_ramp_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Tick decisions
    assign failed   = inv_reg || !hv_reg || (h_reg < H_FAIL);
    assign fail_hit = (phase_reg == PH_STAND) && (count_reg > stand_lim_reg) && failed;
    assign fold_sum = {1'b0, fold_ramp_reg} + {1'b0, fold_settle_reg};
    assign roll_sum = {1'b0, roll_ramp_reg} + {1'b0, roll_settle_reg};
    assign fold_end = count_reg >= (fold_sum[CNT_W] ? CNT_MAX : fold_sum[CNT_W-1:0]);
    assign roll_end = count_reg >= (roll_sum[CNT_W] ? CNT_MAX : roll_sum[CNT_W-1:0]);

    always_comb
    begin
        case (phase_reg)
            PH_STAND: ramp_sel = stand_ramp_reg;
            PH_ROLL:  ramp_sel = roll_ramp_reg;
            default:  ramp_sel = fold_ramp_reg;
        endcase
    end

    assign ramp_go = (st_reg == S_DECIDE) && (op_reg == OP_TICK) && !fail_hit;

    rsjs_ramp u_ramp (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (ramp_go),
        .count   (count_reg),
        .ramp    (ramp_sel),
        .p_valid (p_valid),
        .p       (p)
    );

    // Next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (start && (opcode == OP_ENTER || opcode == OP_TICK))
                begin
                    st_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (op_reg == OP_ENTER)
                begin
                    st_next = S_ENTER_RD;
                end
                else if (fail_hit)
                begin
                    st_next = S_FAIL_RD;
                end
                else
                begin
                    st_next = S_RAMP;
                end
            end
            S_ENTER_RD: st_next = S_ENTER_WR;
            S_ENTER_WR: st_next = idx_end ? S_IDLE : S_ENTER_RD;
            S_FAIL_RD:  st_next = S_FAIL_WR;
            S_FAIL_WR:  st_next = idx_end ? S_IDLE : S_FAIL_RD;
            S_RAMP:     st_next = p_valid ? S_JRD : S_RAMP;
            S_JRD:      st_next = S_JMUL;
            S_JMUL:     st_next = S_JOUT;
            S_JOUT:     st_next = idx_end ? S_IDLE : S_JRD;
            default:    st_next = S_IDLE;
        endcase
    end

    // Memory port steering
    assign tgt_we    = accept && (opcode == OP_LOAD) && (joint < JOINT_W'(NJ))
                       && (table_select != 2'd3);
    assign tgt_waddr = TGT_AW'(table_select) * TGT_AW'(NJ) + TGT_AW'(joint);
    assign tgt_re    = (st_reg == S_ENTER_RD) || (st_reg == S_JRD);
    assign tgt_raddr = ((st_reg == S_JRD) ? TGT_AW'(phase_reg) * TGT_AW'(NJ) : '0)
                       + TGT_AW'(idx_reg);

    assign fb_we = accept && (opcode == OP_STORE) && (joint < JOINT_W'(NJ));
    assign fb_re = (st_reg == S_ENTER_RD) || (st_reg == S_FAIL_RD);

    assign lc_re = (st_reg == S_FAIL_RD);
    assign lc_we = (st_reg == S_JOUT);
    assign sp_re = (st_reg == S_JRD);

    always_comb
    begin
        sp_we    = 1'b0;
        sp_wdata = tgt_q;
        case (st_reg)
            S_ENTER_WR:
            begin
                sp_we    = 1'b1;
                sp_wdata = fb_vld_reg[idx_reg] ? fb_q : tgt_q;
            end
            S_FAIL_WR:
            begin
                sp_we = 1'b1;
                if (fb_vld_reg[idx_reg])
                begin
                    sp_wdata = fb_q;
                end
                else if (lc_vld_reg[idx_reg])
                begin
                    sp_wdata = lc_q;
                end
                else
                begin
                    sp_wdata = '0;
                end
            end
            S_JOUT:
            begin
                sp_we    = restart_reg;
                sp_wdata = tgt_hold_reg;
            end
            default:
            begin
            end
        endcase
    end

    rsjs_ram #(.WIDTH(POS_BITS), .DEPTH(TGT_DEPTH)) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (tgt_waddr),
        .wdata (position),
        .re    (tgt_re),
        .raddr (tgt_raddr),
        .rdata (tgt_q)
    );

    rsjs_ram #(.WIDTH(POS_BITS), .DEPTH(NJ)) u_fb_ram (
        .clk   (clk),
        .we    (fb_we),
        .waddr (IDX_W'(joint)),
        .wdata (position),
        .re    (fb_re),
        .raddr (idx_reg),
        .rdata (fb_q)
    );

    rsjs_ram #(.WIDTH(POS_BITS), .DEPTH(NJ)) u_start_ram (
        .clk   (clk),
        .we    (sp_we),
        .waddr (idx_reg),
        .wdata (sp_wdata),
        .re    (sp_re),
        .raddr (idx_reg),
        .rdata (sp_q)
    );

    rsjs_ram #(.WIDTH(POS_BITS), .DEPTH(NJ)) u_last_ram (
        .clk   (clk),
        .we    (lc_we),
        .waddr (idx_reg),
        .wdata (cmd),
        .re    (lc_re),
        .raddr (idx_reg),
        .rdata (lc_q)
    );

    // Command arithmetic
    assign diff = {tgt_q[POS_BITS-1], tgt_q} - {sp_q[POS_BITS-1], sp_q};
    assign rnd  = prod_reg + PROD_W'(1 << (FRAC_W - 1));
    assign cmd  = POS_BITS'(rnd >>> FRAC_W) + start_hold_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            phase_reg    <= PH_FOLD;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            idx_reg      <= '0;
            fb_vld_reg   <= '0;
            lc_vld_reg   <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            result_valid <= 1'b0;
            if (fb_we)
            begin
                fb_vld_reg[IDX_W'(joint)] <= position_valid;
            end
            case (st_reg)
                S_DECIDE:
                begin
                    idx_reg <= '0;
                    if (op_reg == OP_ENTER)
                    begin
                        count_reg <= '0;
                        done_reg  <= 1'b0;
                        phase_reg <= (!inv_reg && hv_reg && h_reg > H_STAND_LO
                                      && h_reg < H_STAND_HI) ? PH_STAND : PH_FOLD;
                    end
                    else if (!fail_hit && phase_reg == PH_STAND
                             && count_reg >= stand_ramp_reg)
                    begin
                        done_reg <= 1'b1;
                    end
                end
                S_ENTER_WR:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                S_FAIL_WR:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_end)
                    begin
                        phase_reg <= PH_FOLD;
                        count_reg <= '0;
                    end
                end
                S_JOUT:
                begin
                    idx_reg             <= idx_reg + IDX_W'(1);
                    lc_vld_reg[idx_reg] <= 1'b1;
                    result_valid        <= 1'b1;
                    if (idx_end)
                    begin
                        if (restart_reg)
                        begin
                            phase_reg <= nphase_reg;
                            count_reg <= '0;
                        end
                        else if (count_reg != CNT_MAX)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Beat fields, operands and tick decisions
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            inv_reg <= upside_down;
            h_reg   <= height;
            hv_reg  <= height_valid;
        end
        if (st_reg == S_DECIDE)
        begin
            restart_reg <= ((phase_reg == PH_FOLD) && fold_end)
                           || ((phase_reg == PH_ROLL) && roll_end);
            nphase_reg  <= (phase_reg == PH_ROLL) ? PH_FOLD
                           : (inv_reg ? PH_ROLL : PH_STAND);
        end
        if (st_reg == S_JMUL)
        begin
            start_hold_reg <= sp_q;
            tgt_hold_reg   <= tgt_q;
        end
        if (st_reg == S_JOUT)
        begin
            out_joint        <= JOINT_W'(idx_reg);
            position_command <= cmd;
            phase            <= phase_reg;
            complete         <= done_reg;
            last             <= idx_end;
        end
    end

    // Product of offset and ramp point, one joint at a time
    always_ff @(posedge clk)
    begin
        if (st_reg == S_JMUL)
        begin
            prod_reg <= diff * $signed({1'b0, p});
        end
    end

    `RSJS_ASSERT_NOW(a_mid_beat_busy, result_valid && !last, busy,
        "result beat before the twelfth while sequencer idle")
    `RSJS_ASSERT_NOW(a_last_beat_idle, result_valid && last, !busy,
        "sequencer still busy after the twelfth beat")
    `RSJS_ASSERT_NEXT(a_accept_quiet, start && !busy, !result_valid,
        "result beat right after an accepted command")
    `RSJS_ASSERT_NOW(a_phase_code, result_valid, phase != PH_NONE,
        "result beat carries an unused phase code")

endmodule

[verif/tb_top.sv]
// Self-checking testbench of the recovery stand joint sequencer: directed and random beats.
module tb_top;
    import rsjs_pkg::*;

    typedef struct {
        op_t                op;
        logic [3:0]         jnt;
        logic [1:0]         sel;
        logic signed [15:0] pos;
        bit                 pos_ok;
        bit                 inverted;
        logic signed [15:0] hgt;
        bit                 hgt_ok;
    } seq_cmd_t;

    typedef struct {
        logic [3:0]         jnt;
        logic signed [15:0] cmd;
        logic [1:0]         ph;
        bit                 done;
        bit                 tail;
    } joint_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         opcode;
    logic [3:0]         joint;
    logic [1:0]         table_select;
    logic signed [15:0] position;
    logic               position_valid;
    logic               upside_down;
    logic signed [15:0] height;
    logic               height_valid;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               result_valid;
    logic [3:0]         out_joint;
    logic signed [15:0] position_command;
    logic [1:0]         phase;
    logic               complete;
    logic               last;

    // sequencer shadow state
    logic signed [15:0] pose_tbl [3][12];
    logic signed [15:0] fb_angle [12];
    bit                 fb_ok [12];
    logic signed [15:0] ramp_from [12];
    logic signed [15:0] prev_cmd [12];
    phase_t             motion;
    int unsigned        tick_count;
    bit                 stand_done;
    int unsigned        roll_ramp, roll_settle, fold_ramp, fold_settle, stand_ramp;

    joint_cmd_t         cmd_queue [$];
    int                 errors = 0;
    int                 cmds_seen = 0;
    int                 ticks_sent = 0;
    int                 enters_sent = 0;
    int                 gap_pct = 13;

    recovery_stand_joint_sequencer i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .joint(joint), .table_select(table_select),
        .position(position), .position_valid(position_valid),
        .upside_down(upside_down), .height(height), .height_valid(height_valid),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .out_joint(out_joint),
        .position_command(position_command), .phase(phase),
        .complete(complete), .last(last)
    );

    always #10 clk = ~clk;

    // smoothstep point between two poses
    function automatic logic signed [15:0] smooth_pose(int unsigned cnt, int unsigned ramp,
                                                       logic signed [15:0] a,
                                                       logic signed [15:0] b);
        longint unsigned l;
        longint unsigned p;
        longint          d;
        if (cnt >= ramp)
            l = 4096;
        else
            l = (longint'(cnt) * 4096) / ramp;
        p = (l * l * (12288 - 2 * l)) >> 24;
        d = (longint'(b) - longint'(a)) * longint'(p) + 2048;
        return 16'(longint'(a) + (d >>> 12));
    endfunction

    function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
        return (a + b > 65535) ? 65535 : a + b;
    endfunction

    // advance the shadow state by one beat and queue the commands it yields
    task automatic apply_beat(seq_cmd_t c);
        int unsigned ramp;
        joint_cmd_t  e;
        phase_t      ph;
        case (c.op)
            OP_LOAD:
                if (c.jnt < 12 && c.sel < 3) pose_tbl[c.sel][c.jnt] = c.pos;
            OP_STORE:
                if (c.jnt < 12)
                begin
                    fb_angle[c.jnt] = c.pos;
                    fb_ok[c.jnt]    = c.pos_ok;
                end
            OP_ENTER:
            begin
                enters_sent++;
                for (int i = 0; i < 12; i++)
                    ramp_from[i] = fb_ok[i] ? fb_angle[i] : pose_tbl[PH_STAND][i];
                tick_count = 0;
                stand_done = 0;
                motion = (!c.inverted && c.hgt_ok && c.hgt > H_STAND_LO && c.hgt < H_STAND_HI)
                         ? PH_STAND : PH_FOLD;
            end
            default:
            begin
                ticks_sent++;
                ph = motion;
                // stand-up failure: fall back to fold from the current pose
                if (ph == PH_STAND && tick_count > (stand_ramp * 7) / 10 &&
                    (c.inverted || !c.hgt_ok || c.hgt < H_FAIL))
                begin
                    for (int i = 0; i < 12; i++)
                        ramp_from[i] = fb_ok[i] ? fb_angle[i] : prev_cmd[i];
                    motion = PH_FOLD;
                    tick_count = 0;
                    return;
                end
                ramp = (ph == PH_STAND) ? stand_ramp : (ph == PH_ROLL) ? roll_ramp : fold_ramp;
                for (int i = 0; i < 12; i++)
                    prev_cmd[i] = smooth_pose(tick_count, ramp, ramp_from[i], pose_tbl[ph][i]);
                if (ph == PH_STAND && tick_count >= stand_ramp) stand_done = 1;
                for (int i = 0; i < 12; i++)
                begin
                    e.jnt  = 4'(i);
                    e.cmd  = prev_cmd[i];
                    e.ph   = ph;
                    e.done = stand_done;
                    e.tail = (i == 11);
                    cmd_queue.push_back(e);
                end
                // phase end: restart from this phase's targets
                if (ph == PH_FOLD && tick_count >= sat_sum(fold_ramp, fold_settle))
                begin
                    ramp_from = pose_tbl[PH_FOLD];
                    motion = c.inverted ? PH_ROLL : PH_STAND;
                    tick_count = 0;
                end
                else if (ph == PH_ROLL && tick_count >= sat_sum(roll_ramp, roll_settle))
                begin
                    ramp_from = pose_tbl[PH_ROLL];
                    motion = PH_FOLD;
                    tick_count = 0;
                end
                else if (tick_count < 65535)
                    tick_count++;
            end
        endcase
    endtask

    // drive one beat, hold until taken, then maybe idle
    task automatic send_beat(seq_cmd_t c);
        @(negedge clk);
        start          = 1'b1;
        opcode         = c.op;
        joint          = c.jnt;
        table_select   = c.sel;
        position       = c.pos;
        position_valid = c.pos_ok;
        upside_down    = c.inverted;
        height         = c.hgt;
        height_valid   = c.hgt_ok;
        do @(posedge clk); while (busy);
        apply_beat(c);
        if ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(6)) @(negedge clk);
        end
    endtask

    function automatic seq_cmd_t mk(op_t op, int j, int sel, int pos, bit pv, bit up,
                                    int h, bit hv);
        seq_cmd_t c;
        c.op = op;  c.jnt = 4'(j);  c.sel = 2'(sel);  c.pos = 16'(pos);
        c.pos_ok = pv;  c.inverted = up;  c.hgt = 16'(h);  c.hgt_ok = hv;
        return c;
    endfunction

    function automatic int pick_height();
        case ($urandom_range(7))
            0: return 409;
            1: return 410;
            2: return 819;
            3: return 820;
            4: return 1843;
            5: return 1844;
            6: return $urandom_range(2500);
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic seq_cmd_t rand_beat();
        int       r;
        seq_cmd_t c;
        r = $urandom_range(99);
        c = mk(OP_TICK, $urandom_range(15), $urandom_range(3),
               int'($urandom_range(65535)) - 32768, $urandom_range(1),
               ($urandom_range(3) == 0), pick_height(), ($urandom_range(9) != 0));
        if (r >= 87)      c.op = OP_ENTER;
        else if (r >= 75) c.op = OP_LOAD;
        else if (r >= 60) c.op = OP_STORE;
        return c;
    endfunction

    // wait until no command is due and the block has gone quiet
    task automatic wait_quiet();
        @(negedge clk);
        start = 1'b0;
        while (cmd_queue.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int unsigned v);
        @(negedge clk);
        start     = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = 16'(v);
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_ROLL_RAMP:   roll_ramp   = v;
            CFG_ROLL_SETTLE: roll_settle = v;
            CFG_FOLD_RAMP:   fold_ramp   = v;
            CFG_FOLD_SETTLE: fold_settle = v;
            CFG_STAND_RAMP:  stand_ramp  = v;
            default: ;
        endcase
    endtask

    task automatic set_timing(int unsigned rr, int unsigned rs, int unsigned fr,
                              int unsigned fs, int unsigned sr);
        wait_quiet();
        write_reg(CFG_ROLL_RAMP, rr);
        write_reg(CFG_ROLL_SETTLE, rs);
        write_reg(CFG_FOLD_RAMP, fr);
        write_reg(CFG_FOLD_SETTLE, fs);
        write_reg(CFG_STAND_RAMP, sr);
    endtask

    // fill every target entry so that nothing unwritten is ever read
    task automatic test_load_targets();
        for (int t = 0; t < 3; t++)
            for (int j = 0; j < 12; j++)
                send_beat(mk(OP_LOAD, j, t,
                             (j == 0) ? ((t == 1) ? -32768 : 32767)
                                      : int'($urandom_range(65535)) - 32768, 0, 0, 0, 0));
    endtask

    // field extremes, ignored beats, height bounds and the phase changes other than fold to stand
    task automatic test_directed();
        set_timing(1, 0, 1, 0, 2);
        send_beat(mk(OP_LOAD, 12, 0, 100, 0, 0, 0, 0));
        send_beat(mk(OP_LOAD, 15, 1, 100, 0, 0, 0, 0));
        send_beat(mk(OP_LOAD, 3, 3, 100, 0, 0, 0, 0));
        send_beat(mk(OP_STORE, 0, 0, -32768, 1, 0, 0, 0));
        send_beat(mk(OP_STORE, 11, 0, 32767, 1, 0, 0, 0));
        send_beat(mk(OP_STORE, 5, 0, 1234, 0, 0, 0, 0));
        send_beat(mk(OP_STORE, 13, 0, 999, 1, 0, 0, 0));
        send_beat(mk(OP_ENTER, 0, 0, 0, 0, 0, 820, 1));
        repeat (3) send_beat(mk(OP_TICK, 0, 0, 0, 0, 0, 1000, 1));
        send_beat(mk(OP_TICK, 0, 0, 0, 0, 0, 409, 1));
        send_beat(mk(OP_TICK, 0, 0, 0, 0, 1, 1000, 1));
        send_beat(mk(OP_TICK, 0, 0, 0, 0, 1, 1000, 1));
        repeat (3) send_beat(mk(OP_TICK, 0, 0, 0, 0, 0, 1000, 1));
        send_beat(mk(OP_ENTER, 0, 0, 0, 0, 0, 819, 1));
        send_beat(mk(OP_ENTER, 0, 0, 0, 0, 0, 1844, 1));
        send_beat(mk(OP_ENTER, 0, 0, 0, 0, 0, 1843, 0));
        send_beat(mk(OP_ENTER, 0, 0, 0, 0, 1, 1000, 1));
        send_beat(mk(OP_ENTER, 0, 0, 0, 0, 0, 1843, 1));
        send_beat(mk(OP_TICK, 0, 0, 0, 0, 0, 1000, 0));
        send_beat(mk(OP_TICK, 0, 0, 0, 0, 0, 1000, 0));
    endtask

    task automatic test_random(int n);
        repeat (n) send_beat(rand_beat());
    endtask

    // check each command beat against the oldest prediction
    always @(posedge clk)
    begin
        joint_cmd_t e;
        if (rst_n && result_valid)
        begin
            cmds_seen++;
            if (cmd_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected command beat joint %0d cmd %0d", $time, out_joint,
                         position_command);
            end
            else
            begin
                e = cmd_queue.pop_front();
                if (out_joint !== e.jnt || position_command !== e.cmd || phase !== e.ph ||
                    complete !== e.done || last !== e.tail)
                begin
                    errors++;
                    $display("%0t: expected joint %0d cmd %0d phase %0d complete %0b last %0b",
                             $time, e.jnt, e.cmd, e.ph, e.done, e.tail);
                    $display("%0t: actual   joint %0d cmd %0d phase %0d complete %0b last %0b",
                             $time, out_joint, position_command, phase, complete, last);
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("recovery_stand_joint_sequencer: mismatch");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;  start = 1'b0;  opcode = '0;  joint = '0;  table_select = '0;
        position = '0;  position_valid = 1'b0;  upside_down = 1'b0;  height = '0;
        height_valid = 1'b0;  cfg_we = 1'b0;  cfg_index = '0;  cfg_data = '0;
        roll_ramp = 300;  roll_settle = 300;  fold_ramp = 800;  fold_settle = 1400;
        stand_ramp = 500;  motion = PH_FOLD;  tick_count = 0;  stand_done = 0;
        for (int i = 0; i < 12; i++)
        begin
            fb_angle[i] = '0;  fb_ok[i] = 0;  prev_cmd[i] = '0;  ramp_from[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_load_targets();
        test_directed();
        gap_pct = 13;
        set_timing($urandom_range(1, 4), $urandom_range(3), $urandom_range(1, 4),
                   $urandom_range(3), $urandom_range(1, 6));
        test_random(60);
        gap_pct = 76;
        set_timing(65535, 65535, 65535, 65535, 65535);
        test_random(30);
        gap_pct = 0;
        set_timing($urandom_range(2, 8), 0, $urandom_range(2, 8), $urandom_range(4),
                   $urandom_range(2, 10));
        test_random(60);
        set_timing(300, 300, 800, 1400, 500);
        test_random(25);
        wait_quiet();

        $display("covered %0d ticks, %0d recovery entries, %0d command beats checked",
                 ticks_sent, enters_sent, cmds_seen);
        $display("timing set at extremes, reset values and short ramps, with sender gaps");
        if (errors == 0)
            $display("recovery_stand_joint_sequencer: match");
        else
            $display("recovery_stand_joint_sequencer: mismatch");
        $finish;
    end

endmodule
